[rtl/core/pcfe_pkg.sv]
// Shared types and constants of the partition cut fitness evaluator.
package pcfe_pkg;

	// Input and result field widths.
	localparam int NODE_FIELD_W = 6;
	localparam int WEIGHT_W     = 32;
	localparam int PART_W       = 3;
	localparam int CUT_W        = 43;
	localparam int IMB_W        = 11;
	localparam int FIT_W        = 48;
	localparam int FRAC_W       = 12;

	// Part numbers carried by an item never exceed this many slots.
	localparam int PART_SLOTS = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 20;

	localparam int NUM_NODES_W = 7;
	localparam int NUM_PARTS_W = 4;
	localparam int SLACK_W     = 7;
	localparam int PEN_W       = 20;
	localparam int PROD_W      = PEN_W + IMB_W;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PARTS     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_SLACK = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_SCALE = 8'd3;

	localparam logic [NUM_NODES_W-1:0] NUM_NODES_RST = 7'd64;
	localparam logic [NUM_PARTS_W-1:0] NUM_PARTS_RST = 4'd2;
	localparam logic [SLACK_W-1:0]     SLACK_RST     = 7'd2;
	localparam logic [PEN_W-1:0]       PENALTY_RST   = 20'd1000000;

	// Item kinds.
	localparam logic FUNC_WEIGHT = 1'b0;
	localparam logic FUNC_ASSIGN = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_IMB,
		ST_MUL,
		ST_RESULT
	} pcfe_state_t;

	typedef struct packed {
		logic load;
		logic wr_edge;
		logic clr_step;
		logic scan_issue;
		logic commit;
		logic imb_step;
		logic mul;
		logic finish;
	} pcfe_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic func;
		logic last;
		logic node_ok;
		logic has_prev;
		logic scan_last;
		logic pair_end;
	} pcfe_sts_t;

endpackage

[rtl/core/partition_cut_fitness_eval_core.sv]
// Top level of the partition cut fitness evaluator: controller, datapath and result register.
//
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_ready    func, row, col, weight, part, last
// out       out        out_valid / out_ready  cut_weight, imbalance, fitness, bad_part
//
// After reset the edge weight store is swept to zero, one entry per cycle;
// no input beat is taken during the sweep, but configuration beats are.
// A weight beat is taken in and then written to the store as it is decoded.
// The assignment of node k > 0 makes one read per earlier node from the
// weight and part RAMs. The beat marked last adds the pairwise balance pass
// over the P parts in use and the penalty multiply.
// A finished result sits in the output register while new input beats are
// taken; only the next result waits for that register to drain.
module partition_cut_fitness_eval_core #(
	parameter int MAX_NODES = 64,
	parameter int MAX_PARTS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pcfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcfe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [pcfe_pkg::NODE_FIELD_W-1:0] row,
	input  logic [pcfe_pkg::NODE_FIELD_W-1:0] col,
	input  logic [pcfe_pkg::WEIGHT_W-1:0]     weight,
	input  logic [pcfe_pkg::PART_W-1:0]       part,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pcfe_pkg::CUT_W-1:0]        cut_weight,
	output logic [pcfe_pkg::IMB_W-1:0]        imbalance,
	output logic [pcfe_pkg::FIT_W-1:0]        fitness,
	output logic                              bad_part
);

	import pcfe_pkg::*;

	pcfe_cmd_t cmd;
	pcfe_sts_t sts;

	logic             out_free;
	logic [CUT_W-1:0] dp_cut;
	logic [IMB_W-1:0] dp_imb;
	logic [FIT_W-1:0] dp_fit;
	logic             dp_bad;

	logic             out_valid_q;
	logic [CUT_W-1:0] cut_weight_q;
	logic [IMB_W-1:0] imbalance_q;
	logic [FIT_W-1:0] fitness_q;
	logic             bad_part_q;

	// Registers are held in flops and may be written at any cycle.
	assign cfg_ready = 1'b1;

	// The result register can take a new result when empty or draining now.
	assign out_free = !out_valid_q || out_ready;

	pcfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcfe_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_PARTS (MAX_PARTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.func       (func),
		.row        (row),
		.col        (col),
		.weight     (weight),
		.part       (part),
		.last       (last),
		.cmd        (cmd),
		.sts        (sts),
		.cut_weight (dp_cut),
		.imbalance  (dp_imb),
		.fitness    (dp_fit),
		.bad_part   (dp_bad)
	);

	// Output register: loaded when the controller finishes an evaluation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			cut_weight_q <= dp_cut;
			imbalance_q  <= dp_imb;
			fitness_q    <= dp_fit;
			bad_part_q   <= dp_bad;
		end
	end

	assign out_valid  = out_valid_q;
	assign cut_weight = cut_weight_q;
	assign imbalance  = imbalance_q;
	assign fitness    = fitness_q;
	assign bad_part   = bad_part_q;

	// A result is never written over one that has not been taken.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> out_free)
		else $error("result register overwritten before it was taken");

endmodule

[rtl/core/pcfe_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module pcfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/pcfe_ctrl.sv]
// Controller state machine that sequences clearing, scans, balance pass and result.
module pcfe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_free,
	input  pcfe_pkg::pcfe_sts_t sts,
	output pcfe_pkg::pcfe_cmd_t cmd
);

	import pcfe_pkg::*;

	pcfe_state_t state_q;
	pcfe_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.func == FUNC_WEIGHT) begin
					cmd.wr_edge = 1'b1;
					state_d     = ST_IDLE;
				end else if (sts.node_ok) begin
					state_d = sts.has_prev ? ST_SCAN : ST_COMMIT;
				end else begin
					state_d = sts.last ? ST_IMB : ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = sts.last ? ST_IMB : ST_IDLE;
			end
			ST_IMB: begin
				cmd.imb_step = 1'b1;
				if (sts.pair_end) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// No item may enter while the weight store is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("item accepted during clearing pass");

	// The drain state, in which the last scan read lands, is always followed by the commit.
	a_drain_to_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_COMMIT))
		else $error("drain not followed by commit");

	// Datapath commands are mutually exclusive.
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.wr_edge, cmd.clr_step, cmd.scan_issue,
			cmd.commit, cmd.imb_step, cmd.mul, cmd.finish}))
		else $error("overlapping datapath commands");

endmodule

[rtl/core/pcfe_dp.sv]
// Datapath: configuration, item capture, weight and part stores, cut and balance arithmetic.
module pcfe_dp #(
	parameter int MAX_NODES = 64,
	parameter int MAX_PARTS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pcfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcfe_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 func,
	input  logic [pcfe_pkg::NODE_FIELD_W-1:0]    row,
	input  logic [pcfe_pkg::NODE_FIELD_W-1:0]    col,
	input  logic [pcfe_pkg::WEIGHT_W-1:0]        weight,
	input  logic [pcfe_pkg::PART_W-1:0]          part,
	input  logic                                 last,
	input  pcfe_pkg::pcfe_cmd_t                  cmd,
	output pcfe_pkg::pcfe_sts_t                  sts,
	output logic [pcfe_pkg::CUT_W-1:0]           cut_weight,
	output logic [pcfe_pkg::IMB_W-1:0]           imbalance,
	output logic [pcfe_pkg::FIT_W-1:0]           fitness,
	output logic                                 bad_part
);

	import pcfe_pkg::*;

	localparam int NW     = $clog2(MAX_NODES);
	localparam int CW     = $clog2(MAX_NODES + 1);
	localparam int EAW    = 2 * NW;
	localparam int EDEPTH = 1 << EAW;
	localparam int PCW    = $clog2(MAX_PARTS + 3);
	localparam int ENW    = (CW > NUM_NODES_W) ? CW : NUM_NODES_W;
	localparam int DW     = (CW > SLACK_W) ? CW : SLACK_W;

	// Configuration registers.
	logic [NUM_NODES_W-1:0] nn_q;
	logic [NUM_PARTS_W-1:0] np_q;
	logic [SLACK_W-1:0]     slack_q;
	logic [PEN_W-1:0]       pen_q;

	// Captured item.
	logic                    func_q;
	logic [NODE_FIELD_W-1:0] row_q;
	logic [NODE_FIELD_W-1:0] col_q;
	logic [WEIGHT_W-1:0]     weight_q;
	logic [PART_W-1:0]       part_q;
	logic                    last_q;

	// Evaluation state.
	logic [EAW-1:0]    clr_addr_q;
	logic [CW-1:0]     count_q;
	logic [NW-1:0]     j_q;
	logic              rd_vld_s1;
	logic [CUT_W-1:0]  cut_q;
	logic              err_q;
	logic [CW-1:0]     sizes_q [PART_SLOTS];
	logic [IMB_W-1:0]  imb_q;
	logic [PCW-1:0]    pi_q;
	logic [PCW-1:0]    pj_q;
	logic [PROD_W-1:0] prod_s1;

	// Memory ports.
	logic              e_we;
	logic [EAW-1:0]    e_waddr;
	logic [WEIGHT_W-1:0] e_wdata;
	logic [EAW-1:0]    e_raddr;
	logic [WEIGHT_W-1:0] e_rdata;
	logic [PART_W-1:0] n_rdata;

	// Derived values.
	logic [PCW-1:0]    kp_w;
	logic [ENW-1:0]    en_w;
	logic              part_bad;
	logic [PART_W-1:0] part_clamp;
	logic [NW-1:0]     k_w;
	logic              row_ok;
	logic              col_ok;
	logic [NW-1:0]     rn;
	logic [NW-1:0]     cn;
	logic [NW-1:0]     lo;
	logic [NW-1:0]     hi;
	logic [CUT_W:0]    cut_sum;
	logic [CUT_W-1:0]  cut_next;
	logic [CW-1:0]     sz_i;
	logic [CW-1:0]     sz_j;
	logic [DW-1:0]     sa;
	logic [DW-1:0]     sb;
	logic [DW-1:0]     dif;
	logic [DW-1:0]     sl;
	logic [DW-1:0]     exc;
	logic [IMB_W:0]    imb_sum;
	logic [IMB_W-1:0]  imb_next;
	logic              pair_ok;
	logic              more_j;
	logic [PCW:0]      pj_inc;
	logic [PCW:0]      pi2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nn_q    <= NUM_NODES_RST;
			np_q    <= NUM_PARTS_RST;
			slack_q <= SLACK_RST;
			pen_q   <= PENALTY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_NODES:     nn_q    <= cfg_data[NUM_NODES_W-1:0];
				CFG_NUM_PARTS:     np_q    <= cfg_data[NUM_PARTS_W-1:0];
				CFG_BALANCE_SLACK: slack_q <= cfg_data[SLACK_W-1:0];
				CFG_PENALTY_SCALE: pen_q   <= cfg_data[PEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective part count and node limit.
	always_comb begin
		if (np_q == '0) begin
			kp_w = PCW'(1);
		end else if (32'(np_q) > MAX_PARTS) begin
			kp_w = PCW'(MAX_PARTS);
		end else begin
			kp_w = PCW'(np_q);
		end
		if (32'(nn_q) > MAX_NODES) begin
			en_w = ENW'(MAX_NODES);
		end else begin
			en_w = ENW'(nn_q);
		end
	end

	// An out of range part is clamped to the top part, which is then below it.
	assign part_bad   = (PCW + 3)'(part) >= (PCW + 3)'(kp_w);
	assign part_clamp = PART_W'(kp_w - PCW'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			row_q    <= row;
			col_q    <= col;
			weight_q <= weight;
			part_q   <= part_bad ? part_clamp : part;
			last_q   <= last;
		end
	end

	// Only the upper triangle is stored; a scan always reads (earlier, newer).
	assign row_ok  = 32'(row_q) < MAX_NODES;
	assign col_ok  = 32'(col_q) < MAX_NODES;
	assign rn      = NW'(row_q);
	assign cn      = NW'(col_q);
	assign lo      = (rn < cn) ? rn : cn;
	assign hi      = (rn < cn) ? cn : rn;
	assign k_w     = count_q[NW-1:0];
	assign e_we    = cmd.clr_step | (cmd.wr_edge & row_ok & col_ok);
	assign e_waddr = cmd.clr_step ? clr_addr_q : {lo, hi};
	assign e_wdata = cmd.clr_step ? '0 : weight_q;
	assign e_raddr = {j_q, k_w};

	pcfe_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (EDEPTH)
	) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	pcfe_ram #(
		.WIDTH (PART_W),
		.DEPTH (MAX_NODES)
	) u_part_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (k_w),
		.wdata (part_q),
		.raddr (j_q),
		.rdata (n_rdata)
	);

	// Saturating cut accumulation.
	assign cut_sum  = (CUT_W + 1)'(cut_q) + (CUT_W + 1)'(e_rdata);
	assign cut_next = cut_sum[CUT_W] ? '1 : cut_sum[CUT_W-1:0];

	// Part sizes above the slot count are always zero.
	always_comb begin
		sz_i = '0;
		sz_j = '0;
		for (int s = 0; s < PART_SLOTS; s++) begin
			if ((PCW + 3)'(pi_q) == (PCW + 3)'(s)) begin
				sz_i = sizes_q[s];
			end
			if ((PCW + 3)'(pj_q) == (PCW + 3)'(s)) begin
				sz_j = sizes_q[s];
			end
		end
	end

	assign sa       = DW'(sz_i);
	assign sb       = DW'(sz_j);
	assign dif      = (sa > sb) ? (sa - sb) : (sb - sa);
	assign sl       = DW'(slack_q);
	assign exc      = (dif > sl) ? (dif - sl) : '0;
	assign imb_sum  = (IMB_W + 1)'(imb_q) + (IMB_W + 1)'(exc);
	assign imb_next = imb_sum[IMB_W] ? '1 : imb_sum[IMB_W-1:0];

	// Pair walk: (i, j) with i < j < kp, one pair per step.
	assign pair_ok = pj_q < kp_w;
	assign pj_inc  = (PCW + 1)'(pj_q) + (PCW + 1)'(1);
	assign pi2     = (PCW + 1)'(pi_q) + (PCW + 1)'(2);
	assign more_j  = pj_inc < (PCW + 1)'(kp_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			count_q    <= '0;
			j_q        <= '0;
			rd_vld_s1  <= 1'b0;
			cut_q      <= '0;
			err_q      <= 1'b0;
			imb_q      <= '0;
			pi_q       <= '0;
			pj_q       <= PCW'(1);
			for (int s = 0; s < PART_SLOTS; s++) begin
				sizes_q[s] <= '0;
			end
		end else begin
			rd_vld_s1 <= cmd.scan_issue;
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + EAW'(1);
			end
			if (cmd.finish) begin
				count_q <= '0;
				j_q     <= '0;
				cut_q   <= '0;
				err_q   <= 1'b0;
				imb_q   <= '0;
				pi_q    <= '0;
				pj_q    <= PCW'(1);
				for (int s = 0; s < PART_SLOTS; s++) begin
					sizes_q[s] <= '0;
				end
			end else begin
				if (cmd.load && (func == FUNC_ASSIGN) && part_bad) begin
					err_q <= 1'b1;
				end
				if (cmd.scan_issue) begin
					j_q <= j_q + NW'(1);
				end
				if (rd_vld_s1 && (n_rdata != part_q)) begin
					cut_q <= cut_next;
				end
				if (cmd.commit) begin
					count_q         <= count_q + CW'(1);
					sizes_q[part_q] <= sizes_q[part_q] + CW'(1);
					j_q             <= '0;
				end
				if (cmd.imb_step) begin
					if (pair_ok) begin
						imb_q <= imb_next;
					end
					if (more_j) begin
						pj_q <= pj_inc[PCW-1:0];
					end else begin
						pi_q <= pi_q + PCW'(1);
						pj_q <= pi2[PCW-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(pen_q) * PROD_W'(imb_q);
		end
	end

	assign sts.clr_done  = &clr_addr_q;
	assign sts.func      = func_q;
	assign sts.last      = last_q;
	assign sts.node_ok   = ENW'(count_q) < en_w;
	assign sts.has_prev  = count_q != '0;
	assign sts.scan_last = ((CW + 1)'(j_q) + (CW + 1)'(1)) == (CW + 1)'(count_q);
	assign sts.pair_end  = !more_j && (pi2 >= (PCW + 1)'(kp_w));

	// The sum stays below 2^44, so the fitness field never overflows.
	assign cut_weight = cut_q;
	assign imbalance  = imb_q;
	assign fitness    = FIT_W'(cut_q) + FIT_W'({prod_s1, {FRAC_W{1'b0}}});
	assign bad_part   = err_q;

	// A scan is only started for a node that has earlier nodes to compare with.
	a_scan_has_prev: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue |-> sts.has_prev)
		else $error("scan issued with no earlier node");

endmodule

[tb/tb_partition_cut_fitness_eval_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the partition cut fitness evaluator core.
module tb_partition_cut_fitness_eval_core;
	import pcfe_pkg::*;

	localparam int NODE_LIMIT = 64;
	localparam int PART_LIMIT = 8;

	// An index past the last register, with high bits set, must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'hFC;

	// Idle time before a register write or the verdict. The slowest single beat is the
	// assignment of node 63 followed by the balance pass and multiply.
	localparam int QUIET_CYCLES     = 150;
	localparam int RECV_HOLD_CYCLES = 1500;
	// The longest stretch without any accepted beat is the store sweep after reset;
	// the receiver hold-off comes next.
	localparam int WATCHDOG_LIMIT   = 20000;

	localparam int unsigned     IMB_CAP = (1 << IMB_W) - 1;
	localparam longint unsigned CUT_MAX = (64'd1 << CUT_W) - 64'd1;
	localparam longint unsigned FIT_MAX = (64'd1 << FIT_W) - 64'd1;

	// One input beat as queued for the driver. hold_for_drain makes the driver wait
	// until every score due so far has come out before it offers this beat.
	typedef struct {
		logic                    func;
		logic [NODE_FIELD_W-1:0] row;
		logic [NODE_FIELD_W-1:0] col;
		logic [WEIGHT_W-1:0]     weight;
		logic [PART_W-1:0]       part;
		logic                    last;
		bit                      hold_for_drain;
	} graph_beat_t;

	// One result beat: the score of a finished partition.
	typedef struct {
		logic [CUT_W-1:0] cut;
		logic [IMB_W-1:0] imb;
		logic [FIT_W-1:0] fit;
		logic             bad;
	} score_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic                    func      = 1'b0;
	logic [NODE_FIELD_W-1:0] row       = '0;
	logic [NODE_FIELD_W-1:0] col       = '0;
	logic [WEIGHT_W-1:0]     weight    = '0;
	logic [PART_W-1:0]       part      = '0;
	logic                    last      = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [CUT_W-1:0]        cut_weight;
	logic [IMB_W-1:0]        imbalance;
	logic [FIT_W-1:0]        fitness;
	logic                    bad_part;

	partition_cut_fitness_eval_core #(
		.MAX_NODES(NODE_LIMIT),
		.MAX_PARTS(PART_LIMIT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.row       (row),
		.col       (col),
		.weight    (weight),
		.part      (part),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cut_weight(cut_weight),
		.imbalance (imbalance),
		.fitness   (fitness),
		.bad_part  (bad_part)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Traffic shaping, set by the sequence below at falling edges only.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned stall_asks    = 0;
	bit          pause_next    = 1'b0;

	graph_beat_t pending_beats[$];
	score_t      due_scores[$];
	int unsigned beats_queued = 0;
	int unsigned evals_queued = 0;
	int unsigned fail_cnt     = 0;

	// ------------------------------------------------------------------------------
	// Predictor state: the edge weight store, the partition being built and our own
	// copy of the four registers.
	// ------------------------------------------------------------------------------
	bit [WEIGHT_W-1:0] edge_w [NODE_LIMIT][NODE_LIMIT];
	bit [PART_W-1:0]   placed_part [NODE_LIMIT];
	int unsigned       part_size [PART_LIMIT];
	int unsigned       placed_cnt   = 0;
	longint unsigned   cut_acc      = 0;
	bit                saw_bad_part = 1'b0;

	int unsigned reg_nodes   = NUM_NODES_RST;
	int unsigned reg_parts   = NUM_PARTS_RST;
	int unsigned reg_slack   = SLACK_RST;
	int unsigned reg_penalty = PENALTY_RST;

	// A part count of zero behaves as one part, and counts past the hardware limit
	// behave as the limit.
	function automatic int unsigned parts_in_use();
		if (reg_parts == 0) begin
			return 1;
		end
		return (reg_parts > PART_LIMIT) ? PART_LIMIT : reg_parts;
	endfunction

	function automatic int unsigned nodes_in_use();
		return (reg_nodes > NODE_LIMIT) ? NODE_LIMIT : reg_nodes;
	endfunction

	// Applies one accepted beat to the predicted state and, on the closing assignment,
	// queues the score the block must produce.
	task automatic score_beat(input graph_beat_t b);
		int unsigned     kp;
		int unsigned     p;
		int unsigned     i;
		int unsigned     j;
		int unsigned     d;
		int unsigned     imb_acc;
		longint unsigned pen;
		longint unsigned fit;
		score_t          s;
		kp = parts_in_use();
		if (b.func == FUNC_WEIGHT) begin
			edge_w[b.row][b.col] = b.weight;
			edge_w[b.col][b.row] = b.weight;
			return;
		end
		// Out-of-range part numbers fold onto the top part and taint the whole partition.
		p = b.part;
		if (p >= kp) begin
			p = kp - 1;
			saw_bad_part = 1'b1;
		end
		// Nodes past the node limit are dropped, but a last mark on them still scores.
		if (placed_cnt < nodes_in_use()) begin
			for (j = 0; j < placed_cnt; j++) begin
				if (placed_part[j] != p) begin
					cut_acc += edge_w[j][placed_cnt];
					if (cut_acc > CUT_MAX) begin
						cut_acc = CUT_MAX;
					end
				end
			end
			placed_part[placed_cnt] = p;
			part_size[p]++;
			placed_cnt++;
		end
		if (!b.last) begin
			return;
		end
		imb_acc = 0;
		for (i = 0; i < kp; i++) begin
			for (j = i + 1; j < kp; j++) begin
				d = (part_size[i] > part_size[j]) ? part_size[i] - part_size[j]
					: part_size[j] - part_size[i];
				if (d > reg_slack) begin
					imb_acc += d - reg_slack;
				end
			end
		end
		if (imb_acc > IMB_CAP) begin
			imb_acc = IMB_CAP;
		end
		// The penalty is an integer count, so it is shifted up to the Q.12 cut scale.
		pen = reg_penalty;
		pen = (pen * imb_acc) << FRAC_W;
		fit = cut_acc + pen;
		if (fit > FIT_MAX) begin
			fit = FIT_MAX;
		end
		s.cut = CUT_W'(cut_acc);
		s.imb = IMB_W'(imb_acc);
		s.fit = FIT_W'(fit);
		s.bad = saw_bad_part;
		due_scores = {due_scores, s};
		// The partition starts over; edge weights are kept.
		placed_cnt   = 0;
		cut_acc      = 0;
		saw_bad_part = 1'b0;
		for (i = 0; i < PART_LIMIT; i++) begin
			part_size[i] = 0;
		end
	endtask

	// ------------------------------------------------------------------------------
	// Driver: offers queued beats, keeps valid and payload steady until accepted,
	// and hands every accepted beat to the predictor.
	// ------------------------------------------------------------------------------
	graph_beat_t offered;
	graph_beat_t nxt;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				score_beat(offered);
			end
			if (!in_valid || in_ready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				    (!pending_beats[0].hold_for_drain || due_scores.size() == 0)) begin
					nxt = pending_beats.pop_front();
					offered  <= nxt;
					in_valid <= 1'b1;
					func     <= nxt.func;
					row      <= nxt.row;
					col      <= nxt.col;
					weight   <= nxt.weight;
					part     <= nxt.part;
					last     <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------------
	// Monitor: checks each result beat against the oldest due score and drives
	// out_ready, including the long hold-off that backs the block up.
	// ------------------------------------------------------------------------------
	score_t      want;
	int unsigned stall_seen = 0;
	int unsigned hold_left  = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_scores.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10) begin
						$display("result beat with no score due: cut %h imb %0d fit %h bad %b",
							cut_weight, imbalance, fitness, bad_part);
					end
				end else begin
					want = due_scores.pop_front();
					if (cut_weight !== want.cut || imbalance !== want.imb ||
					    fitness !== want.fit || bad_part !== want.bad) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display("score mismatch (want/got): cut %h/%h imb %0d/%0d",
								want.cut, cut_weight, want.imb, imbalance);
							$display("    fit %h/%h bad %b/%b",
								want.fit, fitness, want.bad, bad_part);
						end
					end
				end
			end
			if (stall_asks != stall_seen) begin
				stall_seen = stall_asks;
				hold_left  = RECV_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: any accepted beat on any channel counts as progress.
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_partition_cut_fitness_eval_core NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------------
	task automatic enqueue(input graph_beat_t b);
		b.hold_for_drain = pause_next;
		pause_next = 1'b0;
		pending_beats = {pending_beats, b};
		beats_queued++;
		if (b.func == FUNC_ASSIGN && b.last) begin
			evals_queued++;
		end
	endtask

	// Fields that an item kind does not use are filled with noise.
	task automatic put_weight(input int unsigned r, input int unsigned c,
			input logic [WEIGHT_W-1:0] w);
		graph_beat_t b;
		b.func   = FUNC_WEIGHT;
		b.row    = NODE_FIELD_W'(r);
		b.col    = NODE_FIELD_W'(c);
		b.weight = w;
		b.part   = PART_W'($urandom());
		b.last   = 1'($urandom());
		enqueue(b);
	endtask

	task automatic put_assign(input int unsigned p, input logic is_last);
		graph_beat_t b;
		b.func   = FUNC_ASSIGN;
		b.row    = NODE_FIELD_W'($urandom());
		b.col    = NODE_FIELD_W'($urandom());
		b.weight = $urandom();
		b.part   = PART_W'(p);
		b.last   = is_last;
		enqueue(b);
	endtask

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				// Around one unit in Q20.12.
				return WEIGHT_W'($urandom_range(1 << (FRAC_W + 1)));
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	// Mostly an endpoint among the nodes of the coming partition, so it matters.
	function automatic int unsigned pick_node(input int unsigned span);
		if ($urandom_range(4) == 0) begin
			return $urandom_range(NODE_LIMIT - 1);
		end
		return $urandom_range(span - 1);
	endfunction

	// One partition: a few weight writes, then the node assignments in order, with
	// stray weight writes and an occasional early last mark mixed in.
	task automatic queue_eval();
		int unsigned n;
		int unsigned span;
		int unsigned kp;
		int unsigned i;
		int unsigned p;
		kp = parts_in_use();
		case ($urandom_range(24))
			0: begin
				n = NODE_LIMIT + $urandom_range(3);
			end
			1: begin
				n = 1;
			end
			default: begin
				n = $urandom_range(12, 2);
			end
		endcase
		span = (n < NODE_LIMIT) ? n : NODE_LIMIT;
		repeat ($urandom_range(4)) begin
			put_weight(pick_node(span), pick_node(span), pick_weight());
		end
		for (i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				put_weight(pick_node(span), pick_node(span), pick_weight());
			end
			p = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(kp - 1);
			put_assign(p, (i == n - 1) || ($urandom_range(39) == 0));
		end
	endtask

	task automatic queue_random(input int unsigned beat_goal, input int unsigned eval_goal);
		int unsigned b0;
		int unsigned e0;
		b0 = beats_queued;
		e0 = evals_queued;
		while (beats_queued - b0 < beat_goal || evals_queued - e0 < eval_goal) begin
			queue_eval();
		end
	endtask

	// Register writes go through their own channel; the predictor copy follows.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_NUM_NODES: begin
				reg_nodes = data[NUM_NODES_W-1:0];
			end
			CFG_NUM_PARTS: begin
				reg_parts = data[NUM_PARTS_W-1:0];
			end
			CFG_BALANCE_SLACK: begin
				reg_slack = data[SLACK_W-1:0];
			end
			CFG_PENALTY_SCALE: begin
				reg_penalty = data[PEN_W-1:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	// Waits until everything queued has gone in and every due score has come out,
	// then lets the block finish any weight write or assignment still in flight.
	// Sampling at the falling edge keeps this clear of the driver's updates.
	task automatic wait_quiet();
		while (pending_beats.size() != 0 || in_valid || due_scores.size() != 0) begin
			@(negedge clk);
		end
		repeat (QUIET_CYCLES) begin
			@(negedge clk);
		end
	endtask

	// ------------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------------
	initial begin
		repeat (2) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 11;
		recv_idle_pct = 73;

		// Directed, reset register values. These beats wait out the store sweep.
		// Extreme weights and endpoints, including a self edge at the top corner.
		put_weight(0, 1, '1);
		put_weight(1, 2, 32'h1234_5678);
		put_weight(2, 0, 32'h8000_0001);
		put_weight(63, 63, '0);
		// Three nodes; part 7 is past the two parts in use and folds onto part 1.
		put_assign(0, 1'b0);
		put_assign(1, 1'b0);
		put_assign(7, 1'b1);
		// A partition of a single node.
		put_assign(0, 1'b1);
		// A weight written mid-partition counts for the nodes placed after it.
		put_assign(1, 1'b0);
		put_weight(0, 1, 32'd5);
		put_assign(0, 1'b1);
		wait_quiet();

		// Two nodes in use, part count zero (acts as one), no slack, largest penalty.
		// The spare index must leave every register alone.
		write_reg(CFG_NUM_NODES, 20'd2);
		write_reg(CFG_NUM_PARTS, 20'd0);
		write_reg(CFG_BALANCE_SLACK, 20'd0);
		write_reg(CFG_PENALTY_SCALE, 20'hFFFFF);
		write_reg(CFG_SPARE_IDX, 20'h00001);
		// Assignments past the node limit are dropped but the last mark still scores.
		put_assign(5, 1'b0);
		put_assign(0, 1'b0);
		put_assign(2, 1'b0);
		put_assign(0, 1'b1);
		wait_quiet();
		// Two parts with both nodes on one side: the penalty at its largest applies.
		write_reg(CFG_NUM_PARTS, 20'd2);
		put_assign(1, 1'b0);
		put_assign(1, 1'b1);
		wait_quiet();

		// Register values above their ranges clamp to the hardware limits; a slack equal to the
		// node limit, no penalty.
		write_reg(CFG_NUM_NODES, 20'hFFFFF);
		write_reg(CFG_NUM_PARTS, 20'hFFFFF);
		write_reg(CFG_BALANCE_SLACK, 20'd64);
		write_reg(CFG_PENALTY_SCALE, 20'd0);
		put_assign(7, 1'b0);
		put_assign(3, 1'b0);
		put_assign(7, 1'b1);
		wait_quiet();

		// Random, slow receiver: all parts, no slack.
		write_reg(CFG_NUM_NODES, 20'd64);
		write_reg(CFG_NUM_PARTS, 20'd8);
		write_reg(CFG_BALANCE_SLACK, 20'd0);
		write_reg(CFG_PENALTY_SCALE, CFG_DATA_W'($urandom_range(1048575)));
		queue_random(140, 14);
		wait_quiet();

		// Random, slow sender: a small node limit so that long partitions overflow it.
		send_idle_pct = 73;
		recv_idle_pct = 11;
		write_reg(CFG_NUM_NODES, CFG_DATA_W'($urandom_range(20, 2)));
		write_reg(CFG_NUM_PARTS, 20'd3);
		write_reg(CFG_BALANCE_SLACK, 20'd1);
		write_reg(CFG_PENALTY_SCALE, PENALTY_RST);
		queue_random(140, 14);
		wait_quiet();

		// Random, no idling on either side. The receiver first holds off long enough
		// for the block to back up and stall its input; halfway through, the sender
		// stops until every score due has come out.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_NUM_NODES, 20'd64);
		write_reg(CFG_NUM_PARTS, 20'd4);
		write_reg(CFG_BALANCE_SLACK, 20'd2);
		write_reg(CFG_PENALTY_SCALE, CFG_DATA_W'($urandom_range(1048575)));
		stall_asks++;
		queue_random(70, 7);
		pause_next = 1'b1;
		queue_random(70, 7);
		wait_quiet();

		if (fail_cnt == 0 && due_scores.size() == 0) begin
			$display("tb_partition_cut_fitness_eval_core OK");
		end else begin
			$display("tb_partition_cut_fitness_eval_core NOT OK");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/pcfe_pkg.sv
rtl/core/pcfe_ram.sv
rtl/core/pcfe_ctrl.sv
rtl/core/pcfe_dp.sv
rtl/core/partition_cut_fitness_eval_core.sv
tb/tb_partition_cut_fitness_eval_core.sv
